>>> rtl/core/cst_pkg.sv
// Shared types, constants and the arctangent table of the circle sector fan generator.
package cst_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int CORDIC_ITERS   = 16;
  localparam int CW             = 34;   // CORDIC datapath width, Q2.30 plus guard bits
  localparam int IDX_W          = 10;
  localparam int COORD_W        = 16;
  localparam int RADIUS_W       = 15;
  localparam int STEP_W         = 16;
  localparam int COUNT_W        = 11;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int PROD_W         = IDX_W + STEP_W;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sh026DD3B6A;

  localparam logic [STEP_W-1:0]  ARC_STEP_RST      = 16'd8192;
  localparam logic [COUNT_W-1:0] SEGMENT_COUNT_RST = 11'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_CIRCLE_RADIUS = 3'd2,
    CFG_START_PHASE   = 3'd3,
    CFG_ARC_STEP      = 3'd4,
    CFG_SEGMENT_COUNT = 3'd5
  } cst_cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RADIUS_W-1:0]       circle_radius;
    logic [STEP_W-1:0]         start_phase;
    logic [STEP_W-1:0]         arc_step;
    logic [COUNT_W-1:0]        segment_count;
  } cst_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] segment_index;
  } cst_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] apex_x;
    logic signed [COORD_W-1:0] apex_y;
    logic signed [COORD_W-1:0] rim_a_x;
    logic signed [COORD_W-1:0] rim_a_y;
    logic signed [COORD_W-1:0] rim_b_x;
    logic signed [COORD_W-1:0] rim_b_y;
    logic                      last_segment;
  } cst_out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cst_lane_t;

  typedef struct packed {
    cst_lane_t a;
    cst_lane_t b;
    logic      neg_a;
    logic      neg_b;
    logic      last;
  } cst_link_t;

  function automatic logic signed [CW-1:0] cst_atan(input logic [3:0] i);
    logic signed [CW-1:0] v;
    case (i)
      4'd0:    v = 34'sh020000000;
      4'd1:    v = 34'sh012E4051E;
      4'd2:    v = 34'sh009FB385B;
      4'd3:    v = 34'sh0051111D4;
      4'd4:    v = 34'sh0028B0D43;
      4'd5:    v = 34'sh00145D7E1;
      4'd6:    v = 34'sh000A2F61E;
      4'd7:    v = 34'sh000517C55;
      4'd8:    v = 34'sh00028BE53;
      4'd9:    v = 34'sh000145F2F;
      4'd10:   v = 34'sh0000A2F98;
      4'd11:   v = 34'sh0000517CC;
      4'd12:   v = 34'sh000028BE6;
      4'd13:   v = 34'sh0000145F3;
      4'd14:   v = 34'sh00000A2FA;
      4'd15:   v = 34'sh00000517D;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/cst_if.sv
// Valid/ready stream interfaces for the input, the internal links and the result channel.
interface cst_in_if;
  logic             valid;
  logic             ready;
  cst_pkg::cst_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cst_link_if;
  logic               valid;
  logic               ready;
  cst_pkg::cst_link_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cst_out_if;
  logic              valid;
  logic              ready;
  cst_pkg::cst_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/cst_phase.sv
// Phase front end: index times step, phase wrap, half-plane fold and CORDIC seed.
module cst_phase #(
  parameter int PHASE_BITS = cst_pkg::PHASE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cst_pkg::cst_cfg_t cfg,
  cst_in_if.sink            up,
  cst_link_if.source        dn
);

  localparam int SUM_W  = cst_pkg::PROD_W + 1;
  localparam int STEP_SUM_W = ((PHASE_BITS > cst_pkg::STEP_W) ? PHASE_BITS : cst_pkg::STEP_W) + 1;

  logic                        v1_r;
  logic [cst_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic                        last1_r, last1_nxt;
  logic                        v2_r;
  cst_pkg::cst_link_t          d2_r, d2_nxt;
  logic                        adv1, adv2;

  logic [SUM_W-1:0]      sum_a;
  logic [PHASE_BITS-1:0] ph_a, ph_b;
  logic [STEP_SUM_W-1:0] sum_b;

  // Map a phase onto the right half-plane; the flag asks for negated results.
  function automatic cst_pkg::cst_lane_t seed(input logic [PHASE_BITS-1:0] ph);
    logic [31:0]        ang;
    logic               neg;
    cst_pkg::cst_lane_t l;
    ang    = {ph, {(32 - PHASE_BITS){1'b0}}};
    neg    = ang[31] ^ ang[30];
    ang[31] = ang[31] ^ neg;
    l.x    = cst_pkg::CORDIC_X0;
    l.y    = '0;
    l.z    = cst_pkg::CW'($signed(ang));
    return l;
  endfunction

  function automatic logic flip(input logic [PHASE_BITS-1:0] ph);
    logic [31:0] ang;
    ang = {ph, {(32 - PHASE_BITS){1'b0}}};
    return ang[31] ^ ang[30];
  endfunction

  assign adv2     = !v2_r || dn.ready;
  assign adv1     = !v1_r || adv2;
  assign up.ready = adv1;
  assign dn.valid = v2_r;
  assign dn.data  = d2_r;

  always_comb begin
    prod_nxt  = cst_pkg::PROD_W'(up.data.segment_index) * cst_pkg::PROD_W'(cfg.arc_step);
    last1_nxt = (cst_pkg::COUNT_W'(up.data.segment_index) + 11'd1) == cfg.segment_count;
  end

  always_comb begin
    sum_a        = SUM_W'(cfg.start_phase) + SUM_W'(prod_r);
    ph_a         = sum_a[PHASE_BITS-1:0];
    sum_b        = STEP_SUM_W'(ph_a) + STEP_SUM_W'(cfg.arc_step);
    ph_b         = sum_b[PHASE_BITS-1:0];
    d2_nxt.a     = seed(ph_a);
    d2_nxt.b     = seed(ph_b);
    d2_nxt.neg_a = flip(ph_a);
    d2_nxt.neg_b = flip(ph_b);
    d2_nxt.last  = last1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up.valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up.valid) begin
      prod_r  <= prod_nxt;
      last1_r <= last1_nxt;
    end
    if (adv2 && v1_r) d2_r <= d2_nxt;
  end

endmodule

>>> rtl/core/cst_cordic_stage.sv
// One CORDIC rotation step on both rim lanes, one register stage.
module cst_cordic_stage #(
  parameter int ITER = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  cst_link_if.sink   up,
  cst_link_if.source dn
);

  localparam logic signed [cst_pkg::CW-1:0] ATAN = cst_pkg::cst_atan(4'(ITER));

  logic               v_r;
  cst_pkg::cst_link_t d_r, d_nxt;
  logic               adv;

  function automatic cst_pkg::cst_lane_t rotate(input cst_pkg::cst_lane_t l);
    cst_pkg::cst_lane_t o;
    logic signed [cst_pkg::CW-1:0] xs, ys;
    xs = l.x >>> ITER;
    ys = l.y >>> ITER;
    if (!l.z[cst_pkg::CW-1]) begin
      o.x = l.x - ys;
      o.y = l.y + xs;
      o.z = l.z - ATAN;
    end else begin
      o.x = l.x + ys;
      o.y = l.y - xs;
      o.z = l.z + ATAN;
    end
    return o;
  endfunction

  assign adv      = !v_r || dn.ready;
  assign up.ready = adv;
  assign dn.valid = v_r;
  assign dn.data  = d_r;

  always_comb begin
    d_nxt       = up.data;
    d_nxt.a     = rotate(up.data.a);
    d_nxt.b     = rotate(up.data.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up.valid) d_r <= d_nxt;
  end

endmodule

>>> rtl/core/cst_rim.sv
// Back end: round CORDIC outputs to Q1.15, scale by radius, add center and saturate.
module cst_rim (
  input  logic              clk,
  input  logic              rst_n,
  input  cst_pkg::cst_cfg_t cfg,
  cst_link_if.sink          up,
  cst_out_if.source         dn
);

  typedef struct packed {
    logic signed [15:0] c_a;
    logic signed [15:0] s_a;
    logic signed [15:0] c_b;
    logic signed [15:0] s_b;
    logic               last;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] p_ax;
    logic signed [31:0] p_ay;
    logic signed [31:0] p_bx;
    logic signed [31:0] p_by;
    logic               last;
  } prod_t;

  logic              v1_r, v2_r, v3_r;
  trig_t             d1_r, d1_nxt;
  prod_t             d2_r, d2_nxt;
  cst_pkg::cst_out_t d3_r, d3_nxt;
  logic              adv1, adv2, adv3;
  logic signed [31:0] rad_s;

  function automatic logic signed [15:0] trig_round(input logic signed [cst_pkg::CW-1:0] v,
                                                     input logic neg);
    logic signed [cst_pkg::CW:0] n;
    logic signed [cst_pkg::CW:0] t;
    logic signed [19:0]          q;
    logic signed [15:0]          r;
    n = neg ? -(($bits(n))'(v)) : ($bits(n))'(v);
    t = n + 35'sd16384;
    q = 20'(t >>> 15);
    if (q > 20'sd32767)       r = 16'sd32767;
    else if (q < -20'sd32767) r = -16'sd32767;
    else                      r = 16'(q);
    return r;
  endfunction

  function automatic logic signed [15:0] rim_sat(input logic signed [31:0] p,
                                                  input logic signed [15:0] ctr);
    logic signed [32:0] t;
    logic signed [18:0] s;
    logic signed [15:0] r;
    t = 33'(p) + 33'sd16384;
    s = 19'(t >>> 15) + 19'(ctr);
    if (s > 19'sd32767)       r = 16'sh7FFF;
    else if (s < -19'sd32768) r = 16'sh8000;
    else                      r = 16'(s);
    return r;
  endfunction

  assign adv3     = !v3_r || dn.ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up.ready = adv1;
  assign dn.valid = v3_r;
  assign dn.data  = d3_r;

  assign rad_s = 32'($signed({1'b0, cfg.circle_radius}));

  always_comb begin
    d1_nxt.c_a  = trig_round(up.data.a.x, up.data.neg_a);
    d1_nxt.s_a  = trig_round(up.data.a.y, up.data.neg_a);
    d1_nxt.c_b  = trig_round(up.data.b.x, up.data.neg_b);
    d1_nxt.s_b  = trig_round(up.data.b.y, up.data.neg_b);
    d1_nxt.last = up.data.last;
  end

  always_comb begin
    d2_nxt.p_ax = rad_s * 32'(d1_r.c_a);
    d2_nxt.p_ay = rad_s * 32'(d1_r.s_a);
    d2_nxt.p_bx = rad_s * 32'(d1_r.c_b);
    d2_nxt.p_by = rad_s * 32'(d1_r.s_b);
    d2_nxt.last = d1_r.last;
  end

  always_comb begin
    d3_nxt.apex_x       = cfg.center_x;
    d3_nxt.apex_y       = cfg.center_y;
    d3_nxt.rim_a_x      = rim_sat(d2_r.p_ax, cfg.center_x);
    d3_nxt.rim_a_y      = rim_sat(d2_r.p_ay, cfg.center_y);
    d3_nxt.rim_b_x      = rim_sat(d2_r.p_bx, cfg.center_x);
    d3_nxt.rim_b_y      = rim_sat(d2_r.p_by, cfg.center_y);
    d3_nxt.last_segment = d2_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up.valid) d1_r <= d1_nxt;
    if (adv2 && v1_r)     d2_r <= d2_nxt;
    if (adv3 && v2_r)     d3_r <= d3_nxt;
  end

endmodule

>>> rtl/core/circle_sector_triangle_generator.sv
// Top level of the circle sector fan generator: config registers and the pipeline chain.
//
// Usage: write the six config registers through cfg_we/cfg_index/cfg_wdata while the block
// is empty (center x/y, radius, start phase, arc step, segment count). Then send segment
// indices on in_beat; each accepted beat yields exactly one beat on out_beat carrying the
// center, the rim point at the index, the rim point at index plus one and the last flag.
// Both channels are valid/ready; a beat moves when valid and ready are high at a clock edge.
// Pipeline: 21 register stages (2 phase stages, 16 CORDIC stages, one per rotation step,
// and 3 stages for rounding, radius multiply and center add with saturation).
// Throughput: one index per cycle while out_beat.ready is high; every stage holds its own
// valid bit and takes new data whenever it is empty or its successor moves, so bubbles
// close up under a stall. When the receiver holds out_beat.ready low the pipeline fills,
// then in_beat.ready drops; no beat is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults:
// center 0, radius 0, start phase 0, arc step 8192, segment count 8.
module circle_sector_triangle_generator #(
  parameter int PHASE_BITS = cst_pkg::PHASE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cst_in_if.sink                           in_beat,
  cst_out_if.source                        out_beat,
  input  logic                             cfg_we,
  input  logic [cst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cst_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic signed [cst_pkg::COORD_W-1:0] center_x_r, center_y_r;
  logic [cst_pkg::RADIUS_W-1:0]       circle_radius_r;
  logic [cst_pkg::STEP_W-1:0]         start_phase_r, arc_step_r;
  logic [cst_pkg::COUNT_W-1:0]        segment_count_r;
  cst_pkg::cst_cfg_t                  cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r      <= '0;
      center_y_r      <= '0;
      circle_radius_r <= '0;
      start_phase_r   <= '0;
      arc_step_r      <= cst_pkg::ARC_STEP_RST;
      segment_count_r <= cst_pkg::SEGMENT_COUNT_RST;
    end else if (cfg_we) begin
      case (cst_pkg::cst_cfg_idx_t'(cfg_index))
        cst_pkg::CFG_CENTER_X:      center_x_r      <= $signed(cfg_wdata);
        cst_pkg::CFG_CENTER_Y:      center_y_r      <= $signed(cfg_wdata);
        cst_pkg::CFG_CIRCLE_RADIUS: circle_radius_r <= cfg_wdata[cst_pkg::RADIUS_W-1:0];
        cst_pkg::CFG_START_PHASE:   start_phase_r   <= cfg_wdata;
        cst_pkg::CFG_ARC_STEP:      arc_step_r      <= cfg_wdata;
        cst_pkg::CFG_SEGMENT_COUNT: segment_count_r <= cfg_wdata[cst_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.center_x      = center_x_r;
    cfg.center_y      = center_y_r;
    cfg.circle_radius = circle_radius_r;
    cfg.start_phase   = start_phase_r;
    cfg.arc_step      = arc_step_r;
    cfg.segment_count = segment_count_r;
  end

  cst_link_if link [cst_pkg::CORDIC_ITERS+1] ();

  cst_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .up    (in_beat),
    .dn    (link[0])
  );

  for (genvar i = 0; i < cst_pkg::CORDIC_ITERS; i++) begin : g_cordic
    cst_cordic_stage #(
      .ITER (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .up    (link[i]),
      .dn    (link[i+1])
    );
  end

  cst_rim u_rim (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .up    (link[cst_pkg::CORDIC_ITERS]),
    .dn    (out_beat)
  );

`ifndef SYNTH
  a_apex_is_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.valid |-> (out_beat.data.apex_x == center_x_r &&
                        out_beat.data.apex_y == center_y_r))
    else $error("apex does not match center registers");

  a_last_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.valid && out_beat.data.last_segment |-> segment_count_r != '0)
    else $error("last flag raised with zero segment count");

  a_zero_radius_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.valid && circle_radius_r == '0 |->
      (out_beat.data.rim_a_x == center_x_r && out_beat.data.rim_b_y == center_y_r))
    else $error("zero radius rim point off center");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_beat.valid |-> in_beat.ready)
    else $error("input stalled while output stage is empty");
`endif

endmodule

>>> bench/tb_circle_sector_triangle_generator.sv
// Self-checking testbench of the circle sector fan generator with a CORDIC-based triangle predictor.
module tb_circle_sector_triangle_generator;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [cst_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  localparam longint FAN_ATAN [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  class fan_scoreboard;
    logic signed [cst_pkg::COORD_W-1:0] cx, cy;
    logic [cst_pkg::RADIUS_W-1:0]       radius;
    logic [cst_pkg::STEP_W-1:0]         start, step;
    logic [cst_pkg::COUNT_W-1:0]        count;
    cst_pkg::cst_out_t                  triangle_q[$];
    int                                 failures;

    function new();
      cx = '0;
      cy = '0;
      radius = '0;
      start = '0;
      step = cst_pkg::ARC_STEP_RST;
      count = cst_pkg::SEGMENT_COUNT_RST;
      failures = 0;
    endfunction

    function void write_reg(logic [cst_pkg::CFG_IDX_W-1:0] idx,
                            logic [cst_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        cst_pkg::CFG_CENTER_X:      cx = val;
        cst_pkg::CFG_CENTER_Y:      cy = val;
        cst_pkg::CFG_CIRCLE_RADIUS: radius = val[cst_pkg::RADIUS_W-1:0];
        cst_pkg::CFG_START_PHASE:   start = val;
        cst_pkg::CFG_ARC_STEP:      step = val;
        cst_pkg::CFG_SEGMENT_COUNT: count = val[cst_pkg::COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Fold the left half-plane onto the right, rotate, then flip the signs back.
    function void rotate(logic [15:0] phase, output longint c, output longint s);
      logic [31:0] ang;
      bit          flip;
      longint      x, y, z, nx;
      ang = {phase, 16'h0000};
      flip = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
      if (flip) ang = ang - 32'h8000_0000;
      z = longint'($signed(ang));
      x = 64'sh26DD3B6A;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - FAN_ATAN[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + FAN_ATAN[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = sat((x + 16384) >>> 15, -32767, 32767);
      s = sat((y + 16384) >>> 15, -32767, 32767);
    endfunction

    function void rim(logic [cst_pkg::COUNT_W-1:0] k,
                      output logic signed [cst_pkg::COORD_W-1:0] px,
                      output logic signed [cst_pkg::COORD_W-1:0] py);
      logic [15:0] ph;
      longint      c, s, r;
      ph = start + k * step;
      rotate(ph, c, s);
      r = longint'(radius);
      px = cst_pkg::COORD_W'(sat(cx + ((r * c + 16384) >>> 15), -32768, 32767));
      py = cst_pkg::COORD_W'(sat(cy + ((r * s + 16384) >>> 15), -32768, 32767));
    endfunction

    function void note_input(logic [cst_pkg::IDX_W-1:0] idx);
      cst_pkg::cst_out_t            t;
      logic [cst_pkg::COUNT_W-1:0]  k;
      k = cst_pkg::COUNT_W'(idx);
      t.apex_x = cx;
      t.apex_y = cy;
      rim(k, t.rim_a_x, t.rim_a_y);
      rim(k + 11'd1, t.rim_b_x, t.rim_b_y);
      t.last_segment = (k + 11'd1 == count);
      triangle_q = {triangle_q, t};
    endfunction

    function void cmp_field(string name, logic signed [15:0] want, logic signed [15:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(cst_pkg::cst_out_t got);
      cst_pkg::cst_out_t want;
      if (triangle_q.size() == 0) begin
        failures++;
        $display("%0t unexpected triangle: expected none, got %h", $time, got);
        return;
      end
      want = triangle_q.pop_front();
      cmp_field("apex_x", want.apex_x, got.apex_x);
      cmp_field("apex_y", want.apex_y, got.apex_y);
      cmp_field("rim_a_x", want.rim_a_x, got.rim_a_x);
      cmp_field("rim_a_y", want.rim_a_y, got.rim_a_y);
      cmp_field("rim_b_x", want.rim_b_x, got.rim_b_x);
      cmp_field("rim_b_y", want.rim_b_y, got.rim_b_y);
      cmp_field("last_segment", 16'(want.last_segment), 16'(got.last_segment));
    endfunction

    function int pending();
      return triangle_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [cst_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cst_pkg::CFG_DATA_W-1:0] cfg_wdata;

  cst_in_if  in_if ();
  cst_out_if out_if ();

  fan_scoreboard sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cycle_count = 0;

  circle_sector_triangle_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_if),
    .out_beat  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the next ready level.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_result(out_if.data);
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
      default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
    endcase
  endtask

  task automatic push_index(logic [cst_pkg::IDX_W-1:0] idx);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{segment_index: idx};
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_input(idx);
  endtask

  task automatic drain_fan();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [cst_pkg::CFG_IDX_W-1:0] idx,
                           logic [cst_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Call only with the pipeline empty; the spare index write must leave everything alone.
  task automatic load_fan(logic [15:0] cx, logic [15:0] cy, logic [15:0] r,
                          logic [15:0] start, logic [15:0] step, logic [15:0] count);
    write_reg(cst_pkg::CFG_CENTER_X, cx);
    write_reg(cst_pkg::CFG_CENTER_Y, cy);
    write_reg(cst_pkg::CFG_CIRCLE_RADIUS, r);
    write_reg(cst_pkg::CFG_START_PHASE, start);
    write_reg(cst_pkg::CFG_ARC_STEP, step);
    write_reg(cst_pkg::CFG_SEGMENT_COUNT, count);
    write_reg(CFG_SPARE_IDX, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] cx, cy, r, start, step, count;
    int          hi_idx;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults, quadrant boundaries, saturation, odd counts, zero step.
    set_idling(0);
    push_index(10'd0);
    push_index(10'd7);
    push_index(10'd8);
    drain_fan();
    load_fan(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h4000, 16'd4);
    for (int k = 0; k < 5; k++) push_index(cst_pkg::IDX_W'(k));
    drain_fan();
    load_fan(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'd1);
    push_index(10'd0);
    push_index(10'd1);
    push_index(10'd1023);
    drain_fan();
    set_idling(3);
    load_fan(16'h8000, 16'h7FFF, 16'h7FFF, 16'h2000, 16'hFFFF, 16'd0);
    push_index(10'd0);
    push_index(10'd512);
    push_index(10'd1023);
    drain_fan();
    load_fan(16'h1234, 16'hFA99, 16'd100, 16'h0000, 16'h0000, 16'd1024);
    push_index(10'd1022);
    push_index(10'd1023);
    drain_fan();
    load_fan(16'hFF00, 16'h0100, 16'd256, 16'h1000, 16'h0040, 16'd2047);
    push_index(10'd1023);
    push_index(10'd0);
    drain_fan();

    for (int p = 0; p < 8; p++) begin
      set_idling(p);
      cx = 16'($urandom);
      cy = 16'($urandom);
      r = 16'($urandom_range(0, 32767));
      if (p == 0) begin
        cx = 16'h7FFF; cy = 16'h7FFF; r = 16'h7FFF;
      end else if (p == 1) begin
        cx = 16'h8000; cy = 16'h8000; r = 16'h7FFF;
      end else if (p % 3 == 2) begin
        r = 16'($urandom_range(0, 512));
      end
      case (p % 4)
        0: count = 16'($urandom_range(2, 16));
        1: count = 16'($urandom_range(2, 1024));
        2: count = 16'd1024;
        default: count = 16'($urandom_range(2, 64));
      endcase
      if (p == 7) count = 16'($urandom_range(0, 2047));
      start = 16'($urandom);
      if (count >= 2 && count <= 1024 && $urandom_range(1) == 1) step = 16'(65536 / count);
      else if (p == 5) step = 16'($urandom);
      else step = 16'($urandom_range(0, 32768));
      load_fan(cx, cy, r, start, step, count);
      hi_idx = (count == 0 || count > 1024) ? 1023 : int'(count) - 1;
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(3) != 0) push_index(cst_pkg::IDX_W'($urandom_range(0, hi_idx)));
        else push_index(cst_pkg::IDX_W'($urandom_range(0, 1023)));
      end
      drain_fan();
    end

    repeat (30) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/cst_pkg.sv
rtl/core/cst_if.sv
rtl/core/cst_phase.sv
rtl/core/cst_cordic_stage.sv
rtl/core/cst_rim.sv
rtl/core/circle_sector_triangle_generator.sv
bench/tb_circle_sector_triangle_generator.sv
